/* src/u16u8_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16LE to UTF-8 bounded transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int CAP_W        = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd256;
  localparam int MAX_CAPACITY = 1024;
  localparam int MAX_RESULTS  = 5;
  localparam int CNT_W        = 3;

  // result kinds
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_OK        = 2'd1;
  localparam logic [1:0] KIND_NO_ROOM   = 2'd2;
  localparam logic [1:0] KIND_EXHAUSTED = 2'd3;

  // code point constants
  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [31:0] LOW_BASE   = 32'h0000_DC00;
  localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;
  localparam logic [31:0] LIM_ONE    = 32'h0000_0080;
  localparam logic [31:0] LIM_TWO    = 32'h0000_0800;
  localparam logic [31:0] LIM_THREE  = 32'h0001_0000;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [5:0]  CONT_MASK  = 6'h3F;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        source_end;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } dst_item_t;

  // all results caused by one code unit
  typedef struct packed {
    logic [CNT_W-1:0]                 count;
    dst_item_t [MAX_RESULTS-1:0]      items;
  } group_t;

endpackage
`default_nettype wire

/* src/u16u8_encode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_encode
// Per-string state and the single-pass encoder that turns one code unit into
// its group of result items.
// ----------------------------------------------------------------------------
module u16u8_encode
  import u16u8_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire src_item_t        item,
  input  wire logic [CAP_W-1:0] capacity,
  output group_t                grp
);

  logic [CAP_W-1:0] bytes_written, bytes_written_next;
  logic [9:0]       pending_high, pending_high_next;
  logic             pending_valid, pending_valid_next;
  logic             finished, finished_next;

  logic [CAP_W-1:0] cap_eff;
  logic [31:0]      cp_pair;
  logic [31:0]      cp;
  logic [CNT_W-1:0] nbytes;
  logic             fits;
  logic             room_term;
  logic             is_high;

  assign cap_eff = (32'(capacity) > 32'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : capacity;

  // unchecked pair: low half used as is, 32-bit wraparound
  assign cp_pair = SUPP_BASE + (({22'b0, pending_high} << 10)
                   | (32'(item.code_unit) - LOW_BASE));
  assign cp      = pending_valid ? cp_pair : {16'b0, item.code_unit};

  assign nbytes = (cp < LIM_ONE)   ? 3'd1 :
                  (cp < LIM_TWO)   ? 3'd2 :
                  (cp < LIM_THREE) ? 3'd3 : 3'd4;

  assign fits      = ({1'b0, bytes_written} + 12'(nbytes) + 12'd1) <= {1'b0, cap_eff};
  assign room_term = ({1'b0, bytes_written} + 12'd1) <= {1'b0, cap_eff};
  assign is_high   = (item.code_unit >= HIGH_FIRST) && (item.code_unit <= HIGH_LAST);

  always_comb begin
    logic do_char;
    logic close_str;
    do_char            = 1'b0;
    close_str          = 1'b0;
    grp                = '0;
    bytes_written_next = bytes_written;
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    finished_next      = finished;

    if (finished) begin
      if (item.source_end) begin
        bytes_written_next = '0;
        finished_next      = 1'b0;
      end
    end else if (pending_valid) begin
      pending_valid_next = 1'b0;
      pending_high_next  = '0;
      do_char            = 1'b1;
    end else if (item.code_unit == 16'd0) begin
      grp.count         = 3'd1;
      grp.items[0].kind = room_term ? KIND_OK : KIND_NO_ROOM;
      close_str         = 1'b1;
    end else if (is_high) begin
      if (item.source_end) begin
        grp.count         = 3'd1;
        grp.items[0].kind = KIND_EXHAUSTED;
        close_str         = 1'b1;
      end else begin
        pending_high_next  = item.code_unit[9:0];
        pending_valid_next = 1'b1;
      end
    end else begin
      do_char = 1'b1;
    end

    if (do_char) begin
      if (!fits) begin
        grp.count         = 3'd1;
        grp.items[0].kind = KIND_NO_ROOM;
        close_str         = 1'b1;
      end else begin
        case (nbytes)
          3'd1: begin
            grp.items[0].out_byte = cp[7:0];
          end
          3'd2: begin
            grp.items[0].out_byte = LEAD_TWO | cp[13:6];
            grp.items[1].out_byte = CONT_MARK | {2'b0, cp[5:0] & CONT_MASK};
          end
          3'd3: begin
            grp.items[0].out_byte = LEAD_THREE | cp[19:12];
            grp.items[1].out_byte = CONT_MARK | {2'b0, cp[11:6] & CONT_MASK};
            grp.items[2].out_byte = CONT_MARK | {2'b0, cp[5:0] & CONT_MASK};
          end
          default: begin
            grp.items[0].out_byte = LEAD_FOUR | cp[25:18];
            grp.items[1].out_byte = CONT_MARK | {2'b0, cp[17:12] & CONT_MASK};
            grp.items[2].out_byte = CONT_MARK | {2'b0, cp[11:6] & CONT_MASK};
            grp.items[3].out_byte = CONT_MARK | {2'b0, cp[5:0] & CONT_MASK};
          end
        endcase
        grp.count          = nbytes;
        bytes_written_next = bytes_written + CAP_W'(nbytes);
        if (item.source_end) begin
          grp.items[nbytes].kind = KIND_EXHAUSTED;
          grp.count              = nbytes + 3'd1;
          close_str              = 1'b1;
        end
      end
    end

    if (close_str) begin
      if (item.source_end) begin
        bytes_written_next = '0;
        pending_high_next  = '0;
        pending_valid_next = 1'b0;
        finished_next      = 1'b0;
      end else begin
        finished_next = 1'b1;
      end
    end

    if (grp.count != '0) begin
      grp.items[3'(grp.count - 3'd1)].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written <= '0;
      pending_high  <= '0;
      pending_valid <= 1'b0;
      finished      <= 1'b0;
    end else if (fire) begin
      bytes_written <= bytes_written_next;
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
      finished      <= finished_next;
    end
  end

endmodule
`default_nettype wire

/* src/u16u8_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u16u8_emit
// Result register: holds a group, one transaction out a cycle unless stalled.
// ----------------------------------------------------------------------------
module u16u8_emit
  import u16u8_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire group_t grp,
  output logic        free,
  output logic        dst_valid,
  input  wire logic   dst_stall,
  output dst_item_t   dst_item
);

  dst_item_t [MAX_RESULTS-1:0] items;
  logic [CNT_W-1:0]            count;
  logic                        take;

  assign dst_valid = (count != '0);
  assign take      = dst_valid && !dst_stall;
  assign free      = (count == '0) || ((count == 3'd1) && take);
  assign dst_item  = items[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= grp.count;
    end else if (take) begin
      count <= count - 3'd1;
    end
  end

  // advance the queue toward slot zero on each taken transaction
  always_ff @(posedge clk) begin
    if (load) begin
      items <= grp.items;
    end else if (take) begin
      items <= {dst_item_t'('0), items[MAX_RESULTS-1:1]};
    end
  end

endmodule
`default_nettype wire

/* src/utf16le_to_utf8_bounded.sv */
// Flow: a code unit accepted into the hold register passes through the
//   encoder into the result register once that register is free.
// Throughput: one result byte per cycle while dst_stall is low; a unit that
//   expands to n bytes holds back the next unit until its last byte is taken.
// Reset: synchronous; clears the string state and sets capacity to 256.
`default_nettype none
// ----------------------------------------------------------------------------
// utf16le_to_utf8_bounded
// UTF-16LE to UTF-8 transcoder into a destination of bounded size.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_bounded
  import u16u8_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             src_valid,
  output logic                  src_stall,
  input  wire src_item_t        src_item,
  output logic                  dst_valid,
  input  wire logic             dst_stall,
  output dst_item_t             dst_item
);

  logic [CAP_W-1:0] capacity;
  logic             hold_valid;
  src_item_t        hold_item;
  logic             advance;
  logic             grp_free;
  group_t           grp;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && grp_free;
  assign src_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src_valid && !src_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      hold_item <= src_item;
    end
  end

  u16u8_encode u_encode (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .item     (hold_item),
    .capacity (capacity),
    .grp      (grp)
  );

  u16u8_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .grp       (grp),
    .free      (grp_free),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

`ifndef SYNTH
  a_group_size : assert property (@(posedge clk) disable iff (rst)
    advance |-> (grp.count <= 3'(MAX_RESULTS)))
    else $error("result group larger than the result register");

  a_group_last : assert property (@(posedge clk) disable iff (rst)
    (advance && (grp.count != '0)) |-> grp.items[3'(grp.count - 3'd1)].last)
    else $error("final result of a group not marked last");

  a_status_zero : assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> ((dst_item.kind == KIND_DATA) || (dst_item.out_byte == 8'd0)))
    else $error("status transaction carries a nonzero byte");

  a_stall_held : assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (hold_valid && !grp_free))
    else $error("input stalled while the encoder could advance");
`endif

endmodule
`default_nettype wire
